/* rtl/fpnr_pkg.sv */
// ----------------------------------------------------------------------------
// fpnr_pkg
// Shared types, codes and constants for the non-rounding FP operation unit.
// ----------------------------------------------------------------------------
`default_nettype none
package fpnr_pkg;

  localparam int unsigned ModeW = 4;
  localparam int unsigned DataW = 64;
  localparam int unsigned RegW  = 5;

  typedef enum logic [3:0] {
    OP_SGNJ   = 4'd0,
    OP_SGNJN  = 4'd1,
    OP_SGNJX  = 4'd2,
    OP_MIN    = 4'd3,
    OP_MAX    = 4'd4,
    OP_LE     = 4'd5,
    OP_LT     = 4'd6,
    OP_EQ     = 4'd7,
    OP_CLASS  = 4'd8,
    OP_MV_X   = 4'd9,
    OP_MV_F   = 4'd10
  } op_t;

  localparam logic [3:0] OpLast = 4'd10;

  localparam logic [31:0] QnanS = 32'h7fc0_0000;
  localparam logic [63:0] QnanD = 64'h7ff8_0000_0000_0000;
  localparam logic [63:0] BoxHi = 64'hffff_ffff_0000_0000;

  typedef struct packed {
    logic [3:0]  mode;
    logic        is_double;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic [63:0] int_source;
    logic [4:0]  dest_index;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        writes_int_reg;
    logic [4:0]  dest_index_out;
    logic        invalid_flag;
    logic        marks_dirty;
    logic        illegal;
  } out_beat_t;

  // per-operand decode, format-independent
  typedef struct packed {
    logic sign;
    logic nan;
    logic snan;
    logic inf;
    logic zero;
    logic sub;
    logic [62:0] mag;   // magnitude, zero-extended for single
  } opinfo_t;

  // stage 1 -> stage 2 info
  typedef struct packed {
    logic        ill;
    op_t         op;
    logic        dbl;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] isrc;
    logic [4:0]  rd;
    opinfo_t     ia;
    opinfo_t     ib;
  } s1_t;

  // stage 2 -> stage 3 info
  typedef struct packed {
    logic        ill;
    op_t         op;
    logic        dbl;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] isrc;
    logic [4:0]  rd;
    opinfo_t     ia;
    opinfo_t     ib;
    logic        mag_lt;
    logic        mag_eq;
  } s2_t;

endpackage
`default_nettype wire

/* rtl/fpnr_if.sv */
// ----------------------------------------------------------------------------
// fpnr_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface fpnr_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/fp_non_rounding_ops_unit.sv */
// ----------------------------------------------------------------------------
// fp_non_rounding_ops_unit
// RISC-V F/D sign injection, min/max, compare, classify and moves.
// ----------------------------------------------------------------------------
// Three-stage pipeline: decode/unbox, 63-bit magnitude compare, result select.
// One beat per cycle is accepted unless out_ch back-pressure has filled the
// pipeline; a beat passes through registers r1, r2 and r3 to out_ch. All
// stages hold under stall. fp_enabled is sampled at stage 1.
`default_nettype none
module fp_non_rounding_ops_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  fpnr_if.sink      in_ch,
  fpnr_if.source    out_ch
);

  logic fp_enabled;

  logic              v1, v2, v3;
  fpnr_pkg::s1_t     r1;
  fpnr_pkg::s2_t     r2;
  fpnr_pkg::out_beat_t r3;

  fpnr_pkg::s1_t       d1;
  fpnr_pkg::out_beat_t d3;

  logic en3, en2, en1;

  assign en3 = !v3 || out_ch.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ch.ready = en1;
  assign out_ch.valid = v3;
  assign out_ch.data  = r3;

  fpnr_decode u_dec (
    .fp_enabled (fp_enabled),
    .beat       (in_ch.data),
    .info       (d1)
  );

  fpnr_result u_res (
    .s   (r2),
    .res (d3)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fp_enabled <= 1'b1;
    end else if (cfg_we) begin
      fp_enabled <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_ch.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) r1 <= d1;
    if (en2) begin
      r2.ill    <= r1.ill;
      r2.op     <= r1.op;
      r2.dbl    <= r1.dbl;
      r2.a      <= r1.a;
      r2.b      <= r1.b;
      r2.isrc   <= r1.isrc;
      r2.rd     <= r1.rd;
      r2.ia     <= r1.ia;
      r2.ib     <= r1.ib;
      r2.mag_lt <= r1.ia.mag < r1.ib.mag;
      r2.mag_eq <= r1.ia.mag == r1.ib.mag;
    end
    if (en3) r3 <= d3;
  end

endmodule
`default_nettype wire

/* rtl/fpnr_decode.sv */
// ----------------------------------------------------------------------------
// fpnr_decode
// Stage 1: NaN unboxing, legality check and operand classification.
// ----------------------------------------------------------------------------
`default_nettype none
module fpnr_decode (
  input  wire logic              fp_enabled,
  input  wire fpnr_pkg::in_beat_t beat,
  output fpnr_pkg::s1_t           info
);

  function automatic fpnr_pkg::opinfo_t examine(input logic [63:0] x, input logic dbl);
    fpnr_pkg::opinfo_t r;
    logic        emax;
    logic        ezero;
    logic        mzero;
    logic        qbit;
    r = '0;
    if (dbl) begin
      r.sign = x[63];
      emax   = &x[62:52];
      ezero  = ~|x[62:52];
      mzero  = ~|x[51:0];
      qbit   = x[51];
      r.mag  = x[62:0];
    end else begin
      r.sign = x[31];
      emax   = &x[30:23];
      ezero  = ~|x[30:23];
      mzero  = ~|x[22:0];
      qbit   = x[22];
      r.mag  = {32'd0, x[30:0]};
    end
    r.nan  = emax & ~mzero;
    r.snan = emax & ~mzero & ~qbit;
    r.inf  = emax & mzero;
    r.zero = ezero & mzero;
    r.sub  = ezero & ~mzero;
    return r;
  endfunction

  logic [63:0] a_u;
  logic [63:0] b_u;

  always_comb begin
    a_u = beat.operand_a;
    b_u = beat.operand_b;
    if (!beat.is_double) begin
      a_u = (&beat.operand_a[63:32]) ? {32'd0, beat.operand_a[31:0]}
                                     : {32'd0, fpnr_pkg::QnanS};
      b_u = (&beat.operand_b[63:32]) ? {32'd0, beat.operand_b[31:0]}
                                     : {32'd0, fpnr_pkg::QnanS};
    end
    info.ill  = !fp_enabled || (beat.mode > fpnr_pkg::OpLast);
    info.op   = fpnr_pkg::op_t'(beat.mode);
    info.dbl  = beat.is_double;
    info.a    = a_u;
    info.b    = b_u;
    // move-to-int uses raw bits, keep them in isrc when that op
    info.isrc = (beat.mode == fpnr_pkg::OP_MV_X) ? beat.operand_a : beat.int_source;
    info.rd   = beat.dest_index;
    info.ia   = examine(a_u, beat.is_double);
    info.ib   = examine(b_u, beat.is_double);
  end

endmodule
`default_nettype wire

/* rtl/fpnr_result.sv */
// ----------------------------------------------------------------------------
// fpnr_result
// Stage 3: result selection, flags and boxing.
// ----------------------------------------------------------------------------
`default_nettype none
module fpnr_result (
  input  wire fpnr_pkg::s2_t     s,
  output fpnr_pkg::out_beat_t    res
);

  logic [63:0] sgn_mask;
  logic [63:0] val;
  logic        nv;
  logic        fpw;
  logic        wint;
  logic        dirty;
  logic        any_nan;
  logic        any_snan;
  logic        eq;
  logic        lt;
  logic        sa;
  logic        sb;
  logic [9:0]  cls;

  always_comb begin
    sgn_mask = s.dbl ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
    sa       = s.ia.sign;
    sb       = s.ib.sign;
    any_nan  = s.ia.nan | s.ib.nan;
    any_snan = s.ia.snan | s.ib.snan;
    eq = (s.mag_eq && sa == sb) || (s.ia.zero && s.ib.zero);
    if (sa != sb) lt = sa && !(s.ia.zero && s.ib.zero);
    else          lt = sa ? (!s.mag_lt && !s.mag_eq) : s.mag_lt;

    cls = '0;
    if (s.ia.inf)       cls = sa ? 10'h001 : 10'h080;
    else if (s.ia.nan)  cls = s.ia.snan ? 10'h100 : 10'h200;
    else if (s.ia.zero) cls = sa ? 10'h008 : 10'h010;
    else if (s.ia.sub)  cls = sa ? 10'h004 : 10'h020;
    else                cls = sa ? 10'h002 : 10'h040;

    val  = '0;
    nv   = 1'b0;
    fpw  = 1'b0;
    wint = 1'b0;
    dirty = 1'b0;
    case (s.op)
      fpnr_pkg::OP_SGNJ, fpnr_pkg::OP_SGNJN, fpnr_pkg::OP_SGNJX: begin
        fpw = 1'b1;
        if (s.op == fpnr_pkg::OP_SGNJ)
          val = (s.a & ~sgn_mask) | (s.b & sgn_mask);
        else if (s.op == fpnr_pkg::OP_SGNJN)
          val = (s.a & ~sgn_mask) | (~s.b & sgn_mask);
        else
          val = (s.a & ~sgn_mask) | ((s.a ^ s.b) & sgn_mask);
      end
      fpnr_pkg::OP_MIN, fpnr_pkg::OP_MAX: begin
        fpw = 1'b1;
        nv  = any_snan;
        if (s.ia.nan && s.ib.nan)
          val = s.dbl ? fpnr_pkg::QnanD : {32'd0, fpnr_pkg::QnanS};
        else if (s.ia.nan) val = s.b;
        else if (s.ib.nan) val = s.a;
        else if (eq && sa != sb)
          val = (s.op == fpnr_pkg::OP_MAX) ? 64'd0 : sgn_mask;
        else if (s.op == fpnr_pkg::OP_MAX) val = lt ? s.b : s.a;
        else val = lt ? s.a : s.b;
      end
      fpnr_pkg::OP_LE, fpnr_pkg::OP_LT, fpnr_pkg::OP_EQ: begin
        wint = 1'b1;
        if (any_nan) begin
          nv = (s.op != fpnr_pkg::OP_EQ) || any_snan;
        end else if (s.op == fpnr_pkg::OP_LE) begin
          val = {63'd0, lt | eq};
        end else if (s.op == fpnr_pkg::OP_LT) begin
          val = {63'd0, lt};
        end else begin
          val = {63'd0, eq};
        end
      end
      fpnr_pkg::OP_CLASS: begin
        wint = 1'b1;
        val  = {54'd0, cls};
      end
      fpnr_pkg::OP_MV_X: begin
        wint = 1'b1;
        val  = s.dbl ? s.isrc : {{32{s.isrc[31]}}, s.isrc[31:0]};
      end
      fpnr_pkg::OP_MV_F: begin
        dirty = 1'b1;
        val   = s.dbl ? s.isrc : (fpnr_pkg::BoxHi | {32'd0, s.isrc[31:0]});
      end
      default: ;
    endcase
    if (fpw) begin
      dirty = 1'b1;
      if (!s.dbl) val = fpnr_pkg::BoxHi | {32'd0, val[31:0]};
    end
    if (nv) dirty = 1'b1;

    res.dest_index_out = s.rd;
    if (s.ill) begin
      res.result_value   = '0;
      res.writes_int_reg = 1'b0;
      res.invalid_flag   = 1'b0;
      res.marks_dirty    = 1'b0;
      res.illegal        = 1'b1;
    end else begin
      res.result_value   = val;
      res.writes_int_reg = wint;
      res.invalid_flag   = nv;
      res.marks_dirty    = dirty;
      res.illegal        = 1'b0;
    end
  end

endmodule
`default_nettype wire

/* dv/fp_non_rounding_ops_unit_tb.sv */
// ----------------------------------------------------------------------------
// fp_non_rounding_ops_unit_tb
// Self-checking bench for the non-rounding FP unit: a directed table, then
// random beats with random idling on both channels, checked in order against
// an in-bench prediction of every result field.
// ----------------------------------------------------------------------------
`default_nettype none
module fp_non_rounding_ops_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumRandom  = 1750;
  localparam logic [3:0]  ModeIllegalLo = fpnr_pkg::OpLast + 4'd1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  fpnr_if #(.payload_t(fpnr_pkg::in_beat_t))  in_ch ();
  fpnr_if #(.payload_t(fpnr_pkg::out_beat_t)) out_ch ();

  fp_non_rounding_ops_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // precision format masks
  typedef struct {
    logic [63:0] sgn;
    logic [63:0] expo;
    logic [63:0] frac;
    logic [63:0] quiet;
    logic [63:0] qnan;
  } fmt_mask_t;

  typedef struct {
    fpnr_pkg::in_beat_t  beat;
    logic                check_fixed;
    fpnr_pkg::out_beat_t fixed;
  } stim_row_t;

  fpnr_pkg::out_beat_t result_fifo[$];
  logic       fp_on;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  logic       hold_long = 1'b0;

  function automatic fmt_mask_t fmt_of(logic dbl);
    fmt_mask_t f;
    if (dbl) begin
      f.sgn = 64'h8000_0000_0000_0000; f.expo = 64'h7ff0_0000_0000_0000;
      f.frac = 64'h000f_ffff_ffff_ffff; f.quiet = 64'h0008_0000_0000_0000;
      f.qnan = fpnr_pkg::QnanD;
    end else begin
      f.sgn = 64'h8000_0000; f.expo = 64'h7f80_0000; f.frac = 64'h007f_ffff;
      f.quiet = 64'h0040_0000; f.qnan = {32'h0, fpnr_pkg::QnanS};
    end
    return f;
  endfunction

  function automatic logic nan_p(fmt_mask_t f, logic [63:0] x);
    return (x & ~f.sgn) > f.expo;
  endfunction

  function automatic logic snan_p(fmt_mask_t f, logic [63:0] x);
    return nan_p(f, x) && ((x & f.quiet) == 0);
  endfunction

  function automatic logic eq_p(fmt_mask_t f, logic [63:0] a, logic [63:0] b);
    return (a == b) || (((a & ~f.sgn) == 0) && ((b & ~f.sgn) == 0));
  endfunction

  function automatic logic lt_p(fmt_mask_t f, logic [63:0] a, logic [63:0] b);
    logic [63:0] ma, mb;
    logic sa, sb;
    ma = a & ~f.sgn; mb = b & ~f.sgn;
    sa = (a & f.sgn) != 0; sb = (b & f.sgn) != 0;
    if (sa != sb) return sa && ((ma | mb) != 0);
    return sa ? (ma > mb) : (ma < mb);
  endfunction

  function automatic logic [9:0] class_mask(fmt_mask_t f, logic [63:0] x);
    logic s;
    logic [63:0] e, m;
    s = (x & f.sgn) != 0; e = x & f.expo; m = x & f.frac;
    if (e == f.expo) begin
      if (m == 0) return s ? 10'h001 : 10'h080;
      return ((m & f.quiet) != 0) ? 10'h200 : 10'h100;
    end
    if (e == 0) begin
      if (m == 0) return s ? 10'h008 : 10'h010;
      return s ? 10'h004 : 10'h020;
    end
    return s ? 10'h002 : 10'h040;
  endfunction

  function automatic logic [63:0] unbox_s(logic [63:0] v);
    return (v[63:32] == 32'hffff_ffff) ? {32'h0, v[31:0]} : {32'h0, fpnr_pkg::QnanS};
  endfunction

  function automatic fpnr_pkg::out_beat_t fp_result(fpnr_pkg::in_beat_t t, logic en);
    fpnr_pkg::out_beat_t r;
    fmt_mask_t f;
    logic [63:0] a, b, s;
    logic an, bn, fpw, lt;
    f = fmt_of(t.is_double);
    a = t.is_double ? t.operand_a : unbox_s(t.operand_a);
    b = t.is_double ? t.operand_b : unbox_s(t.operand_b);
    r = '0;
    r.dest_index_out = t.dest_index;
    fpw = 1'b0;
    if (!en || t.mode > fpnr_pkg::OpLast) begin
      r.illegal = 1'b1;
      return r;
    end
    an = nan_p(f, a); bn = nan_p(f, b);
    case (fpnr_pkg::op_t'(t.mode))
      fpnr_pkg::OP_SGNJ, fpnr_pkg::OP_SGNJN, fpnr_pkg::OP_SGNJX: begin
        s = b & f.sgn;
        if (t.mode == fpnr_pkg::OP_SGNJN) s = s ^ f.sgn;
        else if (t.mode == fpnr_pkg::OP_SGNJX) s = (a ^ b) & f.sgn;
        r.result_value = (a & ~f.sgn) | s;
        fpw = 1'b1;
      end
      fpnr_pkg::OP_MIN, fpnr_pkg::OP_MAX: begin
        r.invalid_flag = snan_p(f, a) || snan_p(f, b);
        if (an && bn) r.result_value = f.qnan;
        else if (an) r.result_value = b;
        else if (bn) r.result_value = a;
        else if (eq_p(f, a, b) && (((a ^ b) & f.sgn) != 0))
          r.result_value = (t.mode == fpnr_pkg::OP_MAX) ? 64'h0 : f.sgn;
        else begin
          lt = lt_p(f, a, b);
          r.result_value = (t.mode == fpnr_pkg::OP_MAX) ? (lt ? b : a) : (lt ? a : b);
        end
        fpw = 1'b1;
      end
      fpnr_pkg::OP_LE, fpnr_pkg::OP_LT, fpnr_pkg::OP_EQ: begin
        r.writes_int_reg = 1'b1;
        if (an || bn) begin
          r.invalid_flag = (t.mode != fpnr_pkg::OP_EQ) || snan_p(f, a) || snan_p(f, b);
        end else if (t.mode == fpnr_pkg::OP_LE)
          r.result_value = {63'd0, lt_p(f, a, b) || eq_p(f, a, b)};
        else if (t.mode == fpnr_pkg::OP_LT) r.result_value = {63'd0, lt_p(f, a, b)};
        else r.result_value = {63'd0, eq_p(f, a, b)};
      end
      fpnr_pkg::OP_CLASS: begin
        r.result_value = {54'd0, class_mask(f, a)};
        r.writes_int_reg = 1'b1;
      end
      fpnr_pkg::OP_MV_X: begin
        r.result_value = t.is_double ? t.operand_a
                                     : {{32{t.operand_a[31]}}, t.operand_a[31:0]};
        r.writes_int_reg = 1'b1;
      end
      default: begin
        r.result_value = t.is_double ? t.int_source : {32'hffff_ffff, t.int_source[31:0]};
        r.marks_dirty = 1'b1;
      end
    endcase
    if (fpw) begin
      if (!t.is_double) r.result_value = {32'hffff_ffff, r.result_value[31:0]};
      r.marks_dirty = 1'b1;
    end
    if (r.invalid_flag) r.marks_dirty = 1'b1;
    return r;
  endfunction

  // interesting operand values per precision
  function automatic logic [63:0] pick_fp(logic dbl);
    logic [63:0] v;
    logic [63:0] sg;
    sg = dbl ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
    case ($urandom_range(0, 11))
      0: v = 64'h0;
      1: v = dbl ? 64'h7ff0_0000_0000_0000 : 64'h7f80_0000;
      2: v = dbl ? fpnr_pkg::QnanD : {32'h0, fpnr_pkg::QnanS};
      3: v = dbl ? 64'h7ff0_0000_0000_0001 : 64'h7f80_0001;
      4: v = dbl ? {12'h7ff, 1'b0, 51'($urandom()) | 51'h1}
                 : {32'h0, 9'h0ff, 23'($urandom())};
      5: v = dbl ? {12'h0, 52'({$urandom(), $urandom()})}
                 : {32'h0, 9'h0, 23'($urandom())};
      6: v = dbl ? 64'h3ff0_0000_0000_0000 : 64'h3f80_0000;
      default: v = {$urandom(), $urandom()};
    endcase
    if ($urandom_range(0, 1)) v = v ^ sg;
    if (!dbl) begin
      // mostly boxed, sometimes junk in the upper half
      if ($urandom_range(0, 7) == 0) v[63:32] = $urandom();
      else v[63:32] = 32'hffff_ffff;
    end
    return v;
  endfunction

  function automatic fpnr_pkg::in_beat_t rand_beat();
    fpnr_pkg::in_beat_t t;
    t.is_double = 1'($urandom_range(0, 1));
    t.mode = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(ModeIllegalLo, 15))
                                          : 4'($urandom_range(0, fpnr_pkg::OpLast));
    t.operand_a = pick_fp(t.is_double);
    t.operand_b = ($urandom_range(0, 7) == 0) ? t.operand_a : pick_fp(t.is_double);
    if ($urandom_range(0, 7) == 0) t.operand_b = t.operand_a ^
      (t.is_double ? 64'h8000_0000_0000_0000 : 64'h8000_0000);
    t.int_source = {$urandom(), $urandom()};
    t.dest_index = 5'($urandom());
    return t;
  endfunction

  task automatic send_beat(fpnr_pkg::in_beat_t t, logic chk, fpnr_pkg::out_beat_t fixed);
    fpnr_pkg::out_beat_t p;
    int unsigned gap;
    gap = hold_long ? 0 : $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    p = fp_result(t, fp_on);
    if (chk && p !== fixed) begin
      $display("%0t: table row disagrees with prediction exp %h got %h", $time, fixed, p);
      errors++;
    end
    result_fifo.push_back(p);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (result_fifo.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_enable(logic v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    fp_on = v;
  endtask

  // receiver: random stalls, plus one long hold-off
  initial begin
    int unsigned w;
    out_ch.ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_long <= 1'b0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (w != 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    fpnr_pkg::out_beat_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (result_fifo.size() == 0) begin
        $display("%0t: unexpected beat got %h", $time, out_ch.data);
        errors++;
      end else begin
        e = result_fifo.pop_front();
        if (out_ch.data.result_value !== e.result_value)
          $display("%0t: result_value exp %h got %h", $time, e.result_value,
                   out_ch.data.result_value);
        if (out_ch.data.writes_int_reg !== e.writes_int_reg)
          $display("%0t: writes_int_reg exp %b got %b", $time, e.writes_int_reg,
                   out_ch.data.writes_int_reg);
        if (out_ch.data.dest_index_out !== e.dest_index_out)
          $display("%0t: dest_index_out exp %h got %h", $time, e.dest_index_out,
                   out_ch.data.dest_index_out);
        if (out_ch.data.invalid_flag !== e.invalid_flag)
          $display("%0t: invalid_flag exp %b got %b", $time, e.invalid_flag,
                   out_ch.data.invalid_flag);
        if (out_ch.data.marks_dirty !== e.marks_dirty)
          $display("%0t: marks_dirty exp %b got %b", $time, e.marks_dirty,
                   out_ch.data.marks_dirty);
        if (out_ch.data.illegal !== e.illegal)
          $display("%0t: illegal exp %b got %b", $time, e.illegal, out_ch.data.illegal);
        if (out_ch.data !== e) errors++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("fp_non_rounding_ops_unit_tb: done, errors");
      $finish;
    end
  end

  function automatic stim_row_t row(logic [3:0] m, logic d, logic [63:0] a, logic [63:0] b,
                                    logic [63:0] ix, logic [4:0] rd, logic c,
                                    logic [63:0] rv, logic wi, logic nv, logic dt,
                                    logic il);
    stim_row_t r;
    r.beat = '{mode: m, is_double: d, operand_a: a, operand_b: b, int_source: ix,
               dest_index: rd};
    r.check_fixed = c;
    r.fixed = '{result_value: rv, writes_int_reg: wi, dest_index_out: rd,
                invalid_flag: nv, marks_dirty: dt, illegal: il};
    return r;
  endfunction

  initial begin
    stim_row_t tbl[$];
    logic [63:0] ones;
    ones = '1;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    fp_on = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    tbl.push_back(row(fpnr_pkg::OP_SGNJ, 1'b1, ones, '0, '0, 5'd31, 1'b1,
                      64'h7fff_ffff_ffff_ffff, 1'b0, 1'b0, 1'b1, 1'b0));
    tbl.push_back(row(fpnr_pkg::OP_SGNJN, 1'b1, '0, '0, '0, 5'd0, 1'b1,
                      64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b1, 1'b0));
    tbl.push_back(row(fpnr_pkg::OP_SGNJX, 1'b0, ones, ones, '0, 5'd1, 1'b1,
                      64'hffff_ffff_7fff_ffff, 1'b0, 1'b0, 1'b1, 1'b0));
    tbl.push_back(row(fpnr_pkg::OP_SGNJ, 1'b0, '0, ones, '0, 5'd2, 1'b1,
                      64'hffff_ffff_ffc0_0000, 1'b0, 1'b0, 1'b1, 1'b0));
    tbl.push_back(row(fpnr_pkg::OP_MIN, 1'b1, 64'h7ff0_0000_0000_0001, fpnr_pkg::QnanD, '0,
                      5'd3, 1'b1, fpnr_pkg::QnanD, 1'b0, 1'b1, 1'b1, 1'b0));
    tbl.push_back(row(fpnr_pkg::OP_MAX, 1'b1, 64'h8000_0000_0000_0000, '0, '0, 5'd4, 1'b1,
                      '0, 1'b0, 1'b0, 1'b1, 1'b0));
    tbl.push_back(row(fpnr_pkg::OP_MIN, 1'b1, '0, 64'h8000_0000_0000_0000, '0, 5'd5, 1'b1,
                      64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b1, 1'b0));
    tbl.push_back(row(fpnr_pkg::OP_MAX, 1'b1, fpnr_pkg::QnanD, 64'h3ff0_0000_0000_0000, '0,
                      5'd6, 1'b1, 64'h3ff0_0000_0000_0000, 1'b0, 1'b0, 1'b1, 1'b0));
    tbl.push_back(row(fpnr_pkg::OP_LE, 1'b1, fpnr_pkg::QnanD, '0, '0, 5'd7, 1'b1,
                      '0, 1'b1, 1'b1, 1'b1, 1'b0));
    tbl.push_back(row(fpnr_pkg::OP_LT, 1'b0, 64'hffff_ffff_7fc0_0000, '0, '0, 5'd8, 1'b1,
                      '0, 1'b1, 1'b1, 1'b1, 1'b0));
    tbl.push_back(row(fpnr_pkg::OP_EQ, 1'b1, fpnr_pkg::QnanD, fpnr_pkg::QnanD, '0, 5'd9, 1'b1,
                      '0, 1'b1, 1'b0, 1'b0, 1'b0));
    tbl.push_back(row(fpnr_pkg::OP_EQ, 1'b1, 64'h7ff0_0000_0000_0001, '0, '0, 5'd10, 1'b1,
                      '0, 1'b1, 1'b1, 1'b1, 1'b0));
    tbl.push_back(row(fpnr_pkg::OP_EQ, 1'b1, 64'h8000_0000_0000_0000, '0, '0, 5'd11, 1'b1,
                      64'h1, 1'b1, 1'b0, 1'b0, 1'b0));
    tbl.push_back(row(fpnr_pkg::OP_LE, 1'b1, 64'h8000_0000_0000_0000, '0, '0, 5'd12, 1'b0,
                      '0, 1'b0, 1'b0, 1'b0, 1'b0));
    tbl.push_back(row(fpnr_pkg::OP_LT, 1'b0, 64'hffff_ffff_bf80_0000, 64'hffff_ffff_3f80_0000,
                      '0, 5'd13, 1'b0, '0, 1'b0, 1'b0, 1'b0, 1'b0));
    tbl.push_back(row(fpnr_pkg::OP_CLASS, 1'b1, 64'hfff0_0000_0000_0000, '0, '0, 5'd14, 1'b1,
                      64'h1, 1'b1, 1'b0, 1'b0, 1'b0));
    tbl.push_back(row(fpnr_pkg::OP_CLASS, 1'b0, 64'h7f80_0001, '0, '0, 5'd15, 1'b1,
                      64'h200, 1'b1, 1'b0, 1'b0, 1'b0));
    tbl.push_back(row(fpnr_pkg::OP_CLASS, 1'b0, 64'hffff_ffff_0000_0001, '0, '0, 5'd16, 1'b1,
                      64'h20, 1'b1, 1'b0, 1'b0, 1'b0));
    tbl.push_back(row(fpnr_pkg::OP_MV_X, 1'b0, 64'h0000_0000_8000_0000, '0, '0, 5'd17, 1'b1,
                      64'hffff_ffff_8000_0000, 1'b1, 1'b0, 1'b0, 1'b0));
    tbl.push_back(row(fpnr_pkg::OP_MV_X, 1'b1, ones, '0, '0, 5'd18, 1'b1,
                      ones, 1'b1, 1'b0, 1'b0, 1'b0));
    tbl.push_back(row(fpnr_pkg::OP_MV_F, 1'b0, '0, '0, 64'h1234_5678_0000_0000, 5'd19, 1'b1,
                      64'hffff_ffff_0000_0000, 1'b0, 1'b0, 1'b1, 1'b0));
    tbl.push_back(row(fpnr_pkg::OP_MV_F, 1'b1, '0, '0, ones, 5'd20, 1'b1,
                      ones, 1'b0, 1'b0, 1'b1, 1'b0));
    tbl.push_back(row(ModeIllegalLo, 1'b1, ones, ones, ones, 5'd21, 1'b1,
                      '0, 1'b0, 1'b0, 1'b0, 1'b1));
    tbl.push_back(row(4'hf, 1'b0, ones, ones, ones, 5'd22, 1'b1,
                      '0, 1'b0, 1'b0, 1'b0, 1'b1));
    foreach (tbl[i]) send_beat(tbl[i].beat, tbl[i].check_fixed, tbl[i].fixed);

    // disabled: everything illegal
    write_enable(1'b0);
    repeat (30) send_beat(rand_beat(), 1'b0, '0);
    write_enable(1'b1);

    // back-pressure: receiver holds off while beats keep coming
    hold_long <= 1'b1;
    repeat (40) send_beat(rand_beat(), 1'b0, '0);
    drain();

    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 2) write_enable(1'b0);
      if (i == NumRandom / 2 + 60) write_enable(1'b1);
      send_beat(rand_beat(), 1'b0, '0);
    end
    drain();
    if (errors == 0) begin
      $display("fp_non_rounding_ops_unit_tb: done, clean");
    end else begin
      $display("fp_non_rounding_ops_unit_tb: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
